// ===== src/tcpr_pkg.sv =====
package tcpr_pkg;

  localparam int unsigned MaxIntervalsDef = 8;
  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 17;
  localparam logic [LenW-1:0] BufferSizeRst = 17'd8192;
  localparam logic [SeqW-1:0] StartSeqRst = 32'd0;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StZeroLen  = 3'd1,
    StStale    = 3'd2,
    StBeyond   = 3'd3,
    StFull     = 3'd4
  } status_e;

  localparam logic OpPut = 1'b0;
  localparam logic OpRemove = 1'b1;

  localparam logic RegBufferSize = 1'b0;
  localparam logic RegStartSeq = 1'b1;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan;
    logic walk;
    logic front;
  } cmd_t;

  typedef struct packed {
    logic put_ok;
    logic full;
    logic scan_last;
    logic hit_any;
    logic walk_done;
  } sts_t;

endpackage

// ===== src/tcpr_ctrl.sv =====
module tcpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tcpr_pkg::sts_t sts_i,
  output tcpr_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          result_valid_o
);

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SEval  = 6'b000010,
    SScan  = 6'b000100,
    SWalk  = 6'b001000,
    SFront = 6'b010000,
    SResp  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = SEval;
        end
      end
      SEval: begin
        cmd_o.eval = 1'b1;
        if (sts_i.put_ok) begin
          state_d = sts_i.full ? SScan : SWalk;
        end else begin
          state_d = SResp;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = sts_i.hit_any ? SWalk : SResp;
        end
      end
      SWalk: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = SFront;
        end
      end
      SFront: begin
        cmd_o.front = 1'b1;
        state_d     = SResp;
      end
      SResp: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign busy_o         = (state_q != SIdle);
  assign result_valid_o = (state_q == SResp);

endmodule

// ===== src/tcpr_dp.sv =====
module tcpr_dp #(
  parameter int unsigned MaxIntervals = tcpr_pkg::MaxIntervalsDef,
  localparam int unsigned CntW = $clog2(MaxIntervals + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcpr_pkg::cmd_t            cmd_i,
  output tcpr_pkg::sts_t            sts_o,
  input  logic                      opcode_i,
  input  logic [31:0]               seg_seq_i,
  input  logic [16:0]               seg_length_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  output logic [2:0]                status_o,
  output logic [16:0]               taken_len_o,
  output logic [16:0]               ready_len_o,
  output logic [31:0]               next_seq_o,
  output logic [31:0]               total_ready_o,
  output logic [CntW-1:0]           interval_count_o
);

  localparam int unsigned IdxW = $clog2(MaxIntervals);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxIntervals);

  logic [31:0] start_q [MaxIntervals];
  logic [16:0] len_q   [MaxIntervals];
  logic [31:0] start_d [MaxIntervals];
  logic [16:0] len_d   [MaxIntervals];
  logic [CntW-1:0] cnt_q, cnt_d, rem_q, rem_d;
  logic [31:0] exp_q, exp_d, cum_q, cum_d, seq_q;
  logic [16:0] ino_q, ino_d, buf_q, slen_q, taken_q, taken_d;
  logic        op_q, placed_q, placed_d, hit_q, hit_d;
  logic [2:0]  status_q, status_d;
  logic [32:0] ns_q, ns_d, ne_q, ne_d;

  logic [31:0] s_off;
  logic [32:0] e_off, head_o, head_end, span_len;
  logic        stale, beyond, zero, head_hit, rem_nz;
  logic        pop, push, trim;
  logic [31:0] push_start;
  logic [16:0] push_len, rm_n;
  logic [CntW-1:0] push_pos;

  assign s_off      = seq_q - exp_q;
  assign e_off      = {1'b0, s_off} + {16'b0, slen_q};
  assign stale      = s_off[31];
  assign beyond     = e_off > {16'b0, buf_q};
  assign zero       = (slen_q == '0);
  assign head_o     = {1'b0, start_q[0] - exp_q};
  assign head_end   = head_o + {16'b0, len_q[0]};
  assign head_hit   = (head_end >= {1'b0, s_off}) && (head_o <= e_off);
  assign rem_nz     = (rem_q != '0);
  assign span_len   = ne_q - ns_q;
  assign rm_n       = (slen_q < ino_q) ? slen_q : ino_q;

  assign sts_o.put_ok    = (op_q == tcpr_pkg::OpPut) && !zero && !stale && !beyond;
  assign sts_o.full      = (cnt_q == MaxCnt);
  assign sts_o.scan_last = (rem_q == CntW'(1));
  assign sts_o.hit_any   = hit_q || head_hit;
  assign sts_o.walk_done = !rem_nz && placed_q;

  // Per command: set status and counters, and pop the head slot, append at the tail, or trim the head.
  always_comb begin
    pop        = 1'b0;
    push       = 1'b0;
    trim       = 1'b0;
    push_start = start_q[0];
    push_len   = len_q[0];
    ns_d       = ns_q;
    ne_d       = ne_q;
    placed_d   = placed_q;
    hit_d      = hit_q;
    rem_d      = rem_q;
    status_d   = status_q;
    taken_d    = taken_q;
    exp_d      = exp_q;
    ino_d      = ino_q;
    cum_d      = cum_q;
    if (cmd_i.eval) begin
      ns_d     = {1'b0, s_off};
      ne_d     = e_off;
      placed_d = 1'b0;
      hit_d    = 1'b0;
      rem_d    = cnt_q;
      taken_d  = '0;
      status_d = tcpr_pkg::StOk;
      if (zero) begin
        status_d = tcpr_pkg::StZeroLen;
      end else if (op_q == tcpr_pkg::OpRemove) begin
        if (rm_n != '0 && cnt_q != '0) begin
          exp_d   = exp_q + {15'b0, rm_n};
          ino_d   = ino_q - rm_n;
          taken_d = rm_n;
          if (rm_n >= len_q[0]) begin
            pop = 1'b1;
          end else begin
            trim = 1'b1;
          end
        end
      end else if (stale) begin
        status_d = tcpr_pkg::StStale;
      end else if (beyond) begin
        status_d = tcpr_pkg::StBeyond;
      end else begin
        taken_d = slen_q;
      end
    end
    if (cmd_i.scan) begin
      // Rotate the table once around, noting any overlap.
      pop   = 1'b1;
      push  = 1'b1;
      hit_d = hit_q || head_hit;
      rem_d = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        rem_d = cnt_q;
        if (!(hit_q || head_hit)) begin
          status_d = tcpr_pkg::StFull;
          taken_d  = '0;
        end
      end
    end
    if (cmd_i.walk) begin
      if (rem_nz && placed_q) begin
        pop   = 1'b1;
        push  = 1'b1;
        rem_d = rem_q - CntW'(1);
      end else if (rem_nz && head_end < {1'b0, s_off}) begin
        pop   = 1'b1;
        push  = 1'b1;
        rem_d = rem_q - CntW'(1);
      end else if (rem_nz && head_o <= e_off) begin
        pop   = 1'b1;
        rem_d = rem_q - CntW'(1);
        if (head_o < ns_q) ns_d = head_o;
        if (head_end > ne_q) ne_d = head_end;
      end else if (!placed_q) begin
        push       = 1'b1;
        push_start = exp_q + ns_q[31:0];
        push_len   = span_len[16:0];
        placed_d   = 1'b1;
      end
    end
    if (cmd_i.front) begin
      if (cnt_q != '0 && start_q[0] == exp_q) begin
        cum_d = cum_q + {15'b0, len_q[0]} - {15'b0, ino_q};
        ino_d = len_q[0];
      end
    end
  end

  assign push_pos = cnt_q - CntW'(pop);
  assign cnt_d    = cnt_q - CntW'(pop) + CntW'(push);

  always_comb begin
    for (int k = 0; k < MaxIntervals; k++) begin
      start_d[k] = start_q[k];
      len_d[k]   = len_q[k];
      if (pop && k < MaxIntervals - 1) begin
        start_d[k] = start_q[k+1];
        len_d[k]   = len_q[k+1];
      end
      if (push && push_pos[IdxW-1:0] == IdxW'(k)) begin
        start_d[k] = push_start;
        len_d[k]   = push_len;
      end
    end
    if (trim) begin
      start_d[0] = start_q[0] + {15'b0, rm_n};
      len_d[0]   = len_q[0] - rm_n;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxIntervals; k++) begin
      start_q[k] <= start_d[k];
      len_q[k]   <= len_d[k];
    end
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      seq_q  <= seg_seq_i;
      slen_q <= seg_length_i;
    end
    ns_q     <= ns_d;
    ne_q     <= ne_d;
    placed_q <= placed_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    taken_q  <= taken_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
      exp_q <= tcpr_pkg::StartSeqRst;
      ino_q <= '0;
      cum_q <= '0;
      buf_q <= tcpr_pkg::BufferSizeRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tcpr_pkg::RegBufferSize) begin
        buf_q <= cfg_data_i[16:0];
      end else begin
        cnt_q <= '0;
        exp_q <= cfg_data_i;
        ino_q <= '0;
        cum_q <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
      exp_q <= exp_d;
      ino_q <= ino_d;
      cum_q <= cum_d;
    end
  end

  assign status_o         = status_q;
  assign taken_len_o      = taken_q;
  assign ready_len_o      = ino_q;
  assign next_seq_o       = exp_q;
  assign total_ready_o    = cum_q;
  assign interval_count_o = cnt_q;

endmodule

// ===== src/tcp_reassembly_interval_tracker_core.sv =====
// Channel   Direction  Handshake                     Payload
// command   in         start_i, busy_o               opcode_i, seg_seq_i, seg_length_i
// result    out        result_valid_o (1-cycle)      status_o, taken_len_o, ready_len_o,
//                                                    next_seq_o, total_ready_o,
//                                                    interval_count_o
// config    in         cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// A transaction runs from the accept through evaluation to the result for a remove or a
// refused put. A put also walks the interval queue, rotating each interval held or merging
// it into the segment, then places the merged interval and updates the in-order front. A full
// table first scans the queue for an overlap; with none found the put ends there, else it walks.
// Reset clears the table, loads the default buffer size and start sequence.
// The result strobe lasts one cycle; the receiver cannot stall it.
module tcp_reassembly_interval_tracker_core #(
  parameter int unsigned MaxIntervals = tcpr_pkg::MaxIntervalsDef,
  localparam int unsigned CntW = $clog2(MaxIntervals + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            opcode_i,
  input  logic [31:0]     seg_seq_i,
  input  logic [16:0]     seg_length_i,
  output logic            result_valid_o,
  output logic [2:0]      status_o,
  output logic [16:0]     taken_len_o,
  output logic [16:0]     ready_len_o,
  output logic [31:0]     next_seq_o,
  output logic [31:0]     total_ready_o,
  output logic [CntW-1:0] interval_count_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [31:0]     cfg_data_i
);

  tcpr_pkg::cmd_t cmd;
  tcpr_pkg::sts_t sts;

  // Take configuration only between transactions.
  assign cfg_ready_o = !busy_o;

  tcpr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  tcpr_dp #(
    .MaxIntervals (MaxIntervals)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .seg_seq_i        (seg_seq_i),
    .seg_length_i     (seg_length_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .status_o         (status_o),
    .taken_len_o      (taken_len_o),
    .ready_len_o      (ready_len_o),
    .next_seq_o       (next_seq_o),
    .total_ready_o    (total_ready_o),
    .interval_count_o (interval_count_o)
  );

endmodule
